>>> rtl/timer_heap_task_scheduler_defines.svh
// Assertion macros used by the timer heap scheduler RTL.
`ifndef TIMER_HEAP_TASK_SCHEDULER_DEFINES_SVH
`define TIMER_HEAP_TASK_SCHEDULER_DEFINES_SVH
`ifndef ASSERT_OFF
`define TMHQ_ASSERT_IMPL(lbl, ck, rs, pre, post, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) \
    else $error(msg);
`define TMHQ_ASSERT_NEXT(lbl, ck, rs, pre, post, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) \
    else $error(msg);
`else
`define TMHQ_ASSERT_IMPL(lbl, ck, rs, pre, post, msg)
`define TMHQ_ASSERT_NEXT(lbl, ck, rs, pre, post, msg)
`endif
`endif

>>> rtl/tmhq_pkg.sv
// Shared widths, operation codes and status codes of the timer heap scheduler.
package tmhq_pkg;

  localparam int OP_W       = 2;
  localparam int TIME_W     = 32;
  localparam int ID_W       = 8;
  localparam int DELAY_W    = 16;
  localparam int PERIOD_W   = 16;
  localparam int OCC_W      = 5;
  localparam int STATUS_W   = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_POLL   = 2'd1;
  localparam logic [OP_W-1:0] OP_RETIRE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

>>> rtl/tmhq_req_if.sv
// Request channel: one operation beat into the timer heap scheduler.
interface tmhq_req_if;
  logic                                valid;
  logic                                ready;
  logic [tmhq_pkg::OP_W-1:0]           op;
  logic [tmhq_pkg::TIME_W-1:0]         now;
  logic [tmhq_pkg::ID_W-1:0]           task_id;
  logic [tmhq_pkg::DELAY_W-1:0]        delay;
  logic [tmhq_pkg::PERIOD_W-1:0]       period;
  logic                                keep;

  modport source (output valid, op, now, task_id, delay, period, keep, input ready);
  modport sink   (input valid, op, now, task_id, delay, period, keep, output ready);
endinterface

>>> rtl/tmhq_rsp_if.sv
// Response channel: one result beat out of the timer heap scheduler.
interface tmhq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                due;
  logic [tmhq_pkg::ID_W-1:0]           head_id;
  logic [tmhq_pkg::OCC_W-1:0]          occupancy;
  logic [tmhq_pkg::STATUS_W-1:0]       status;

  modport source (output valid, due, head_id, occupancy, status, input ready);
  modport sink   (input valid, due, head_id, occupancy, status, output ready);
endinterface

>>> rtl/tmhq_mem.sv
// Heap entry memory: one write port, two read ports with registered read data.
module tmhq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 56,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> rtl/timer_heap_task_scheduler.sv
// Timer queue kept as a binary min-heap in one memory, with its control sequencer.
//
// Usage: the request channel (req) carries one operation per beat: insert a
// task at now plus delay, poll the head, or retire the head (re-arm it by its
// period when keep is set and the period is nonzero, otherwise remove it).
// The response channel (rsp) returns exactly one beat per request with the
// due flag, the handle at the root, the occupancy and a status code.
// The heap lives in a memory with one write and two read ports. A sift walks
// one level per pair of states: a read state issues the read of the parent or
// of both children, a compare state compares and writes the displaced entry
// back. The moving entry rides in a register, so each level costs one write.
// A poll or a refused operation goes straight to the root read and the result
// state; an insert first sifts up, a retire first loads the root and the last
// entry and then sifts down, each sift moving at most log2 of HEAP_DEPTH levels.
// One request is in flight at a time; the sift sequencer sets the rate.
// A finished response sits in an output register, so the next request is
// taken while the previous response still waits; only a response that is
// ready to load behind a stalled one holds the sequencer.
// Reset empties the heap and drops any pending response; memory contents
// are not cleared: data read at or above the occupancy is never used.
`include "timer_heap_task_scheduler_defines.svh"

module timer_heap_task_scheduler #(
  parameter int HEAP_DEPTH  = 16,
  parameter int HANDLE_BITS = 8
) (
  input logic        clk,
  input logic        rst,
  tmhq_req_if.sink   req,
  tmhq_rsp_if.source rsp
);

  localparam int IDX_W = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam int CMP_W = IDX_W + 2;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HEAP_DEPTH);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP_RD   = 3'd1;
  localparam logic [2:0] S_UP_CMP  = 3'd2;
  localparam logic [2:0] S_RT_LD   = 3'd3;
  localparam logic [2:0] S_DN_RD   = 3'd4;
  localparam logic [2:0] S_DN_CMP  = 3'd5;
  localparam logic [2:0] S_RD_ROOT = 3'd6;
  localparam logic [2:0] S_RES     = 3'd7;

  typedef struct packed {
    logic [tmhq_pkg::TIME_W-1:0]   deadline;
    logic [tmhq_pkg::PERIOD_W-1:0] period;
    logic [HANDLE_BITS-1:0]        handle;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  logic [2:0]                    state;
  logic [CNT_W-1:0]              cnt;
  logic [IDX_W-1:0]              pos;
  entry_t                        cur;
  logic [tmhq_pkg::TIME_W-1:0]   now_r;
  logic                          keep_r;
  logic [tmhq_pkg::STATUS_W-1:0] status_r;

  logic                          res_valid;
  logic                          res_due;
  logic [tmhq_pkg::ID_W-1:0]     res_head;
  logic [tmhq_pkg::OCC_W-1:0]    res_occ;
  logic [tmhq_pkg::STATUS_W-1:0] res_status;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  entry_t               mem_wdata;
  logic [IDX_W-1:0]     mem_raddr_a;
  logic [IDX_W-1:0]     mem_raddr_b;
  logic [ENTRY_W-1:0]   rdata_a_raw;
  logic [ENTRY_W-1:0]   rdata_b_raw;
  entry_t               rd_a;
  entry_t               rd_b;

  tmhq_mem #(
    .DEPTH (HEAP_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (rdata_a_raw),
    .rdata_b (rdata_b_raw)
  );

  assign rd_a = entry_t'(rdata_a_raw);
  assign rd_b = entry_t'(rdata_b_raw);

  // Handshake and heap address arithmetic.
  logic                 req_fire;
  logic                 res_load;
  logic [IDX_W-1:0]     parent;
  logic [IDX_W:0]       child_l;
  logic [IDX_W:0]       child_r;
  logic [CMP_W-1:0]     cnt_x;
  logic                 dn_leaf;
  logic                 has_r;
  logic                 up_go;
  logic                 pick_r;
  entry_t               pick;
  logic [IDX_W-1:0]     pick_idx;
  logic                 dn_go;
  logic [CNT_W-1:0]     cnt_dec;
  logic [CNT_W+IDX_W-1:0] last_wide;
  logic [CNT_W+IDX_W-1:0] cnt_wide;
  logic [HANDLE_BITS+tmhq_pkg::ID_W-1:0] id_in_wide;
  logic [HANDLE_BITS+tmhq_pkg::ID_W-1:0] id_out_wide;
  logic [CNT_W+tmhq_pkg::OCC_W-1:0]      occ_wide;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign res_load  = (state == S_RES) && (!res_valid || rsp.ready);

  assign parent  = IDX_W'((pos - IDX_W'(1)) >> 1);
  assign child_l = {pos, 1'b1};
  assign child_r = child_l + (IDX_W + 1)'(1);
  assign cnt_x   = CMP_W'(cnt);
  assign dn_leaf = CMP_W'(child_l) >= cnt_x;
  assign has_r   = CMP_W'(child_r) < cnt_x;

  assign up_go    = cur.deadline < rd_a.deadline;
  assign pick_r   = has_r && (rd_b.deadline < rd_a.deadline);
  assign pick     = pick_r ? rd_b : rd_a;
  assign pick_idx = pick_r ? child_r[IDX_W-1:0] : child_l[IDX_W-1:0];
  assign dn_go    = pick.deadline < cur.deadline;

  assign cnt_dec   = cnt - CNT_W'(1);
  assign last_wide = {{IDX_W{1'b0}}, cnt_dec};
  assign cnt_wide  = {{IDX_W{1'b0}}, cnt};

  assign id_in_wide  = {{HANDLE_BITS{1'b0}}, req.task_id};
  assign id_out_wide = {{tmhq_pkg::ID_W{1'b0}}, rd_a.handle};
  assign occ_wide    = {{tmhq_pkg::OCC_W{1'b0}}, cnt};

  // Memory port control. Read port A idles on the root so its data holds
  // steady while a response waits to load.
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = pos;
    mem_wdata   = cur;
    mem_raddr_a = '0;
    mem_raddr_b = '0;
    unique case (state)
      S_IDLE: begin
        mem_raddr_b = last_wide[IDX_W-1:0];
      end
      S_UP_RD: begin
        if (pos == '0) begin
          mem_we = 1'b1;
        end else begin
          mem_raddr_a = parent;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (up_go) begin
          mem_wdata = rd_a;
        end
      end
      S_DN_RD: begin
        if (dn_leaf) begin
          mem_we = (cnt != '0);
        end else begin
          mem_raddr_a = child_l[IDX_W-1:0];
          mem_raddr_b = child_r[IDX_W-1:0];
        end
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (dn_go) begin
          mem_wdata = pick;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            now_r    <= req.now;
            keep_r   <= req.keep;
            status_r <= tmhq_pkg::ST_OK;
            priority if (req.op == tmhq_pkg::OP_INSERT) begin
              if (cnt == CNT_FULL) begin
                status_r <= tmhq_pkg::ST_FULL;
                state    <= S_RD_ROOT;
              end else begin
                cur.deadline <= req.now + tmhq_pkg::TIME_W'(req.delay);
                cur.period   <= req.period;
                cur.handle   <= id_in_wide[HANDLE_BITS-1:0];
                pos          <= cnt_wide[IDX_W-1:0];
                cnt          <= cnt + CNT_W'(1);
                state        <= S_UP_RD;
              end
            end else if (req.op == tmhq_pkg::OP_RETIRE) begin
              if (cnt == '0) begin
                status_r <= tmhq_pkg::ST_EMPTY;
                state    <= S_RD_ROOT;
              end else begin
                state <= S_RT_LD;
              end
            end else begin
              state <= S_RD_ROOT;
            end
          end
        end
        S_UP_RD: begin
          state <= (pos == '0) ? S_RD_ROOT : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (up_go) begin
            pos   <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_RD_ROOT;
          end
        end
        S_RT_LD: begin
          if ((rd_a.period != '0) && keep_r) begin
            cur.deadline <= rd_a.deadline + tmhq_pkg::TIME_W'(rd_a.period);
            cur.period   <= rd_a.period;
            cur.handle   <= rd_a.handle;
          end else begin
            cur <= rd_b;
            cnt <= cnt_dec;
          end
          pos   <= '0;
          state <= S_DN_RD;
        end
        S_DN_RD: begin
          state <= dn_leaf ? S_RD_ROOT : S_DN_CMP;
        end
        S_DN_CMP: begin
          if (dn_go) begin
            pos   <= pick_idx;
            state <= S_DN_RD;
          end else begin
            state <= S_RD_ROOT;
          end
        end
        S_RD_ROOT: begin
          state <= S_RES;
        end
        S_RES: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Response payload register; an empty heap reports handle zero, not due.
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_due    <= (cnt != '0) && (rd_a.deadline <= now_r);
      res_head   <= (cnt != '0) ? id_out_wide[tmhq_pkg::ID_W-1:0] : '0;
      res_occ    <= occ_wide[tmhq_pkg::OCC_W-1:0];
      res_status <= status_r;
    end
  end

  assign rsp.valid     = res_valid;
  assign rsp.due       = res_due;
  assign rsp.head_id   = res_head;
  assign rsp.occupancy = res_occ;
  assign rsp.status    = res_status;

  // Checks on the sequencer.
  `TMHQ_ASSERT_NEXT(a_full_insert_holds, clk, rst, req_fire && (req.op == tmhq_pkg::OP_INSERT) && (cnt == CNT_FULL), cnt == $past(cnt), "insert into a full heap changed the count")
  `TMHQ_ASSERT_NEXT(a_retire_step, clk, rst, req_fire && (req.op == tmhq_pkg::OP_RETIRE), (cnt == $past(cnt)) && (state == S_RT_LD || state == S_RD_ROOT), "retire took an unexpected path")
  `TMHQ_ASSERT_IMPL(a_write_in_heap, clk, rst, mem_we, CMP_W'(mem_waddr) < cnt_x, "heap write beyond the occupied slots")

endmodule
